// File: design/sled_pkg.sv
// Shared types and constants for the string literal escape decoder.
// Used by sled_core, sled_out and string_literal_escape_decoder; depends on nothing.
package sled_pkg;

    // Decoder mode, one-hot coded.
    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_ESCAPE  = 4'b0010,
        MODE_HEX     = 4'b0100,
        MODE_PERCENT = 4'b1000
    } mode_t;

    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_CLOSED = 2'd1;
    localparam logic [1:0] END_INTERP = 2'd2;
    localparam logic [1:0] END_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_NO_PAREN     = 3'd2;
    localparam logic [2:0] ERR_NESTED       = 3'd3;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;
    localparam logic [2:0] ERR_UNTERM_UNI   = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd6;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_PERCENT   = 8'h25;
    localparam logic [7:0] CHAR_LPAREN    = 8'h28;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] end_kind;
        logic [2:0] error_code;
    } result_t;

    // Up to three results for one item; res[0] goes out first.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// File: design/sled_core.sv
// Decode state and per-item decode logic of the string literal escape decoder.
// Depends on sled_pkg.
module sled_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          in_byte,
    input  logic                interpolation_open,
    output sled_pkg::bundle_t   bundle
);

    sled_pkg::mode_t mode_reg, mode_next;
    logic [1:0]      digits_reg, digits_next;
    logic [11:0]     acc_reg, acc_next;

    logic [4:0]      hex;
    logic [15:0]     cp;

    function automatic sled_pkg::result_t data_res(input logic [7:0] b);
        sled_pkg::result_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.end_kind   = sled_pkg::END_NONE;
        r.error_code = sled_pkg::ERR_NONE;
        return r;
    endfunction

    function automatic sled_pkg::result_t end_res(input logic [1:0] kind,
                                                  input logic [2:0] err);
        sled_pkg::result_t r;
        r.out_byte   = 8'h00;
        r.byte_valid = 1'b0;
        r.end_kind   = kind;
        r.error_code = err;
        return r;
    endfunction

    assign hex = sled_pkg::hex_value(in_byte);
    assign cp  = {acc_reg, hex[3:0]};

    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        bundle      = '0;
        unique case (mode_reg)
            sled_pkg::MODE_ESCAPE:
            begin
                mode_next    = sled_pkg::MODE_NORMAL;
                bundle.count = 2'd1;
                case (in_byte)
                    sled_pkg::CHAR_ZERO:      bundle.res[0] = data_res(8'h00);
                    sled_pkg::CHAR_A:         bundle.res[0] = data_res(8'h07);
                    sled_pkg::CHAR_B:         bundle.res[0] = data_res(8'h08);
                    sled_pkg::CHAR_F:         bundle.res[0] = data_res(8'h0C);
                    sled_pkg::CHAR_N:         bundle.res[0] = data_res(8'h0A);
                    sled_pkg::CHAR_R:         bundle.res[0] = data_res(8'h0D);
                    sled_pkg::CHAR_T:         bundle.res[0] = data_res(8'h09);
                    sled_pkg::CHAR_QUOTE:     bundle.res[0] = data_res(sled_pkg::CHAR_QUOTE);
                    sled_pkg::CHAR_BACKSLASH: bundle.res[0] = data_res(sled_pkg::CHAR_BACKSLASH);
                    sled_pkg::CHAR_U:
                    begin
                        mode_next    = sled_pkg::MODE_HEX;
                        digits_next  = 2'd0;
                        acc_next     = 12'd0;
                        bundle.count = 2'd0;
                    end
                    default:
                    begin
                        digits_next   = 2'd0;
                        acc_next      = 12'd0;
                        bundle.res[0] = end_res(sled_pkg::END_ERROR,
                                                sled_pkg::ERR_BAD_ESCAPE);
                    end
                endcase
            end
            sled_pkg::MODE_HEX:
            begin
                if (in_byte == sled_pkg::CHAR_NUL || !hex[4]) begin
                    mode_next     = sled_pkg::MODE_NORMAL;
                    digits_next   = 2'd0;
                    acc_next      = 12'd0;
                    bundle.count  = 2'd1;
                    bundle.res[0] = end_res(sled_pkg::END_ERROR,
                                            (in_byte == sled_pkg::CHAR_NUL) ?
                                            sled_pkg::ERR_UNTERM_UNI : sled_pkg::ERR_BAD_HEX);
                end else if (digits_reg == 2'd3) begin
                    mode_next   = sled_pkg::MODE_NORMAL;
                    digits_next = 2'd0;
                    acc_next    = 12'd0;
                    // UTF-8 length follows from the leading zero bits of the code point.
                    if (cp[15:7] == 9'd0) begin
                        bundle.count  = 2'd1;
                        bundle.res[0] = data_res({1'b0, cp[6:0]});
                    end else if (cp[15:11] == 5'd0) begin
                        bundle.count  = 2'd2;
                        bundle.res[0] = data_res({3'b110, cp[10:6]});
                        bundle.res[1] = data_res({2'b10, cp[5:0]});
                    end else begin
                        bundle.count  = 2'd3;
                        bundle.res[0] = data_res({4'b1110, cp[15:12]});
                        bundle.res[1] = data_res({2'b10, cp[11:6]});
                        bundle.res[2] = data_res({2'b10, cp[5:0]});
                    end
                end else begin
                    digits_next = digits_reg + 2'd1;
                    acc_next    = cp[11:0];
                end
            end
            sled_pkg::MODE_PERCENT:
            begin
                mode_next    = sled_pkg::MODE_NORMAL;
                digits_next  = 2'd0;
                acc_next     = 12'd0;
                bundle.count = 2'd1;
                if (in_byte != sled_pkg::CHAR_LPAREN) begin
                    bundle.res[0] = end_res(sled_pkg::END_ERROR, sled_pkg::ERR_NO_PAREN);
                end else if (interpolation_open) begin
                    bundle.res[0] = end_res(sled_pkg::END_ERROR, sled_pkg::ERR_NESTED);
                end else begin
                    bundle.res[0] = end_res(sled_pkg::END_INTERP, sled_pkg::ERR_NONE);
                end
            end
            default:
            begin
                bundle.count = 2'd1;
                case (in_byte)
                    sled_pkg::CHAR_NUL:
                    begin
                        digits_next   = 2'd0;
                        acc_next      = 12'd0;
                        bundle.res[0] = end_res(sled_pkg::END_ERROR,
                                                sled_pkg::ERR_UNTERMINATED);
                    end
                    sled_pkg::CHAR_QUOTE:
                    begin
                        digits_next   = 2'd0;
                        acc_next      = 12'd0;
                        bundle.res[0] = end_res(sled_pkg::END_CLOSED, sled_pkg::ERR_NONE);
                    end
                    sled_pkg::CHAR_PERCENT:
                    begin
                        mode_next    = sled_pkg::MODE_PERCENT;
                        bundle.count = 2'd0;
                    end
                    sled_pkg::CHAR_BACKSLASH:
                    begin
                        mode_next    = sled_pkg::MODE_ESCAPE;
                        bundle.count = 2'd0;
                    end
                    default: bundle.res[0] = data_res(in_byte);
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= sled_pkg::MODE_NORMAL;
            digits_reg <= 2'd0;
            acc_reg    <= 12'd0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// File: design/sled_out.sv
// Result register of the string literal escape decoder: holds the results of
// one item and hands them out one per cycle while m_axis_tready is high. Depends on sled_pkg.
module sled_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sled_pkg::bundle_t   bundle,
    output logic                load_ok,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // out_byte
    output logic [5:0]          m_axis_tuser,   // byte_valid, end_kind[1:0], error_code[2:0]
    output logic                m_axis_tlast    // last
);

    sled_pkg::result_t [2:0] res_reg;
    logic [1:0]              rem_reg, rem_next;
    logic [1:0]              idx_reg, idx_next;
    sled_pkg::result_t       cur;
    logic                    pop;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = res_reg[0];
            2'd1:    cur = res_reg[1];
            default: cur = res_reg[2];
        endcase
    end

    assign m_axis_tvalid = (rem_reg != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = cur.out_byte;
    assign m_axis_tuser  = {cur.error_code, cur.end_kind, cur.byte_valid};
    assign m_axis_tlast  = (rem_reg == 2'd1);

    // A new item may load as the last pending result leaves.
    assign load_ok = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_axis_tready);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load) begin
            rem_next = bundle.count;
            idx_next = 2'd0;
        end else if (pop) begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= bundle.res;
        end
    end

endmodule

// File: design/string_literal_escape_decoder.sv
// String literal escape decoder, top level. Depends on sled_pkg, sled_core, sled_out.
// An accepted item is held in the input register and decoded combinationally; it is loaded
// into the result register when the output can take it, and its first result is offered from there.
// Throughput: one item per cycle while the output keeps up; an item whose \u escape expands to two or
// three UTF-8 bytes holds the result register until all of its bytes have left.
// Reset (rst_n low, asynchronous) empties both registers and returns to normal mode.
module string_literal_escape_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tuser,   // interpolation_open
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [5:0]  m_axis_tuser,   // byte_valid, end_kind[1:0], error_code[2:0]
    output logic        m_axis_tlast    // last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_open_reg;
    logic              advance;
    logic              load_ok;
    sled_pkg::bundle_t bundle;

    // Items that cause no result move on even while the output is busy.
    assign advance       = in_valid_reg && ((bundle.count == 2'd0) || load_ok);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_open_reg <= s_axis_tuser;
        end
    end

    sled_core u_core
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .in_byte            (in_byte_reg),
        .interpolation_open (in_open_reg),
        .bundle             (bundle)
    );

    sled_out u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && (bundle.count != 2'd0)),
        .bundle        (bundle),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: test/string_literal_escape_decoder_test.sv
// Self-checking testbench for string_literal_escape_decoder: drives literal body bytes,
// decodes them in parallel and compares every output item. Depends on sled_pkg and the RTL.
module string_literal_escape_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       interp_open;
    } source_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] end_kind;
        logic [2:0] error_code;
        logic       last;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tuser = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [5:0] m_axis_tuser;
    logic       m_axis_tlast;

    source_item_t pending_bytes[$];
    decoded_t     decoded_bytes[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int failures = 0;
    int cycle_count = 0;

    // Decoder state as seen by the prediction.
    sled_pkg::mode_t decode_state = sled_pkg::MODE_NORMAL;
    logic [1:0]      hex_count = 2'd0;
    logic [15:0]     code_point = 16'h0000;

    string_literal_escape_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic queue_result(input logic [7:0] b, input logic valid, input logic [1:0] kind,
                                input logic [2:0] code, input logic last);
        decoded_t r;
        r.out_byte = b;
        r.byte_valid = valid;
        r.end_kind = kind;
        r.error_code = code;
        r.last = last;
        decoded_bytes.push_back(r);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        queue_result(b, 1'b1, sled_pkg::END_NONE, sled_pkg::ERR_NONE, last);
    endtask

    task automatic end_literal(input logic [1:0] kind, input logic [2:0] code);
        decode_state = sled_pkg::MODE_NORMAL;
        hex_count = 2'd0;
        code_point = 16'h0000;
        queue_result(8'h00, 1'b0, kind, code, 1'b1);
    endtask

    // Advances the predicted decoder by one accepted item and queues what it yields.
    task automatic decode_source_byte(input logic [7:0] c, input logic interp_open);
        logic [7:0]  nibble;
        logic        is_hex;
        logic [15:0] cp;
        nibble = 8'h00;
        is_hex = 1'b1;
        case (decode_state)
            sled_pkg::MODE_ESCAPE:
            begin
                decode_state = sled_pkg::MODE_NORMAL;
                case (c)
                    sled_pkg::CHAR_ZERO:      queue_byte(8'h00, 1'b1);
                    sled_pkg::CHAR_A:         queue_byte(8'h07, 1'b1);
                    sled_pkg::CHAR_B:         queue_byte(8'h08, 1'b1);
                    sled_pkg::CHAR_F:         queue_byte(8'h0C, 1'b1);
                    sled_pkg::CHAR_N:         queue_byte(8'h0A, 1'b1);
                    sled_pkg::CHAR_R:         queue_byte(8'h0D, 1'b1);
                    sled_pkg::CHAR_T:         queue_byte(8'h09, 1'b1);
                    sled_pkg::CHAR_QUOTE:     queue_byte(sled_pkg::CHAR_QUOTE, 1'b1);
                    sled_pkg::CHAR_BACKSLASH: queue_byte(sled_pkg::CHAR_BACKSLASH, 1'b1);
                    sled_pkg::CHAR_U:
                    begin
                        decode_state = sled_pkg::MODE_HEX;
                        hex_count = 2'd0;
                        code_point = 16'h0000;
                    end
                    default: end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_BAD_ESCAPE);
                endcase
            end
            sled_pkg::MODE_HEX:
            begin
                if (c >= sled_pkg::CHAR_ZERO && c <= CHAR_NINE)
                    nibble = c - sled_pkg::CHAR_ZERO;
                else if (c >= sled_pkg::CHAR_A && c <= sled_pkg::CHAR_F)
                    nibble = c - sled_pkg::CHAR_A + 8'd10;
                else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
                    nibble = c - CHAR_UP_A + 8'd10;
                else
                    is_hex = 1'b0;
                if (c == sled_pkg::CHAR_NUL)
                    end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_UNTERM_UNI);
                else if (!is_hex)
                    end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_BAD_HEX);
                else
                begin
                    cp = {code_point[11:0], nibble[3:0]};
                    if (hex_count == 2'd3)
                    begin
                        decode_state = sled_pkg::MODE_NORMAL;
                        hex_count = 2'd0;
                        code_point = 16'h0000;
                        if (cp < 16'h0080)
                            queue_byte(cp[7:0], 1'b1);
                        else if (cp < 16'h0800)
                        begin
                            queue_byte({3'b110, cp[10:6]}, 1'b0);
                            queue_byte({2'b10, cp[5:0]}, 1'b1);
                        end
                        else
                        begin
                            queue_byte({4'b1110, cp[15:12]}, 1'b0);
                            queue_byte({2'b10, cp[11:6]}, 1'b0);
                            queue_byte({2'b10, cp[5:0]}, 1'b1);
                        end
                    end
                    else
                    begin
                        code_point = cp;
                        hex_count = hex_count + 2'd1;
                    end
                end
            end
            sled_pkg::MODE_PERCENT:
            begin
                // The byte after a percent sign is consumed whatever it is.
                if (c != sled_pkg::CHAR_LPAREN)
                    end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_NO_PAREN);
                else if (interp_open)
                    end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_NESTED);
                else
                    end_literal(sled_pkg::END_INTERP, sled_pkg::ERR_NONE);
            end
            default:
            begin
                if (c == sled_pkg::CHAR_NUL)
                    end_literal(sled_pkg::END_ERROR, sled_pkg::ERR_UNTERMINATED);
                else if (c == sled_pkg::CHAR_QUOTE)
                    end_literal(sled_pkg::END_CLOSED, sled_pkg::ERR_NONE);
                else if (c == sled_pkg::CHAR_PERCENT)
                    decode_state = sled_pkg::MODE_PERCENT;
                else if (c == sled_pkg::CHAR_BACKSLASH)
                    decode_state = sled_pkg::MODE_ESCAPE;
                else
                    queue_byte(c, 1'b1);
            end
        endcase
    endtask

    task automatic queue_source(input logic [7:0] b, input logic interp_open);
        source_item_t s;
        s.in_byte = b;
        s.interp_open = interp_open;
        pending_bytes.push_back(s);
    endtask

    task automatic queue_text(input string text, input logic interp_open);
        for (int i = 0; i < text.len(); i++)
            queue_source(text[i], interp_open);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nibble, input logic upper);
        if (nibble < 4'd10)
            return sled_pkg::CHAR_ZERO + nibble;
        return (upper ? CHAR_UP_A : sled_pkg::CHAR_A) + nibble - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter(input int idx);
        case (idx)
            0:       return sled_pkg::CHAR_ZERO;
            1:       return sled_pkg::CHAR_A;
            2:       return sled_pkg::CHAR_B;
            3:       return sled_pkg::CHAR_F;
            4:       return sled_pkg::CHAR_N;
            5:       return sled_pkg::CHAR_R;
            6:       return sled_pkg::CHAR_T;
            7:       return sled_pkg::CHAR_QUOTE;
            default: return sled_pkg::CHAR_BACKSLASH;
        endcase
    endfunction

    // Mostly well-formed literal fragments with random content, plus broken ones and noise.
    task automatic queue_random_fragments(input int count);
        int         start;
        int         sel;
        int         width_class;
        logic [7:0] b;
        logic [15:0] cp;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == sled_pkg::CHAR_QUOTE || b == sled_pkg::CHAR_PERCENT ||
                    b == sled_pkg::CHAR_BACKSLASH)
                    b = b ^ 8'h40;
                queue_source(b, coin());
            end
            else if (sel < 55)
            begin
                queue_source(sled_pkg::CHAR_BACKSLASH, coin());
                queue_source(escape_letter($urandom_range(0, 8)), coin());
            end
            else if (sel < 72)
            begin
                // Spread code points over the one, two and three byte encodings.
                width_class = $urandom_range(0, 2);
                if (width_class == 0)
                    cp = 16'($urandom_range(0, 16'h007F));
                else if (width_class == 1)
                    cp = 16'($urandom_range(16'h0080, 16'h07FF));
                else
                    cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                queue_text("\\u", coin());
                for (int i = 3; i >= 0; i--)
                    queue_source(hex_char(cp[i*4 +: 4], coin()), coin());
            end
            else if (sel < 80)
                queue_text("%(", coin());
            else if (sel < 85)
                queue_source(coin() ? sled_pkg::CHAR_QUOTE : sled_pkg::CHAR_NUL, coin());
            else if (sel < 93)
            begin
                width_class = $urandom_range(0, 2);
                if (width_class == 0)
                    queue_source(sled_pkg::CHAR_BACKSLASH, coin());
                else if (width_class == 1)
                begin
                    queue_text("\\u", coin());
                    repeat ($urandom_range(0, 3))
                        queue_source(hex_char(4'($urandom_range(0, 15)), coin()), coin());
                end
                else
                    queue_source(sled_pkg::CHAR_PERCENT, coin());
                queue_source(8'($urandom_range(0, 255)), coin());
            end
            else
                queue_source(8'($urandom_range(0, 255)), coin());
        end
    endtask

    function automatic string describe(input decoded_t r);
        return $sformatf("byte %02h valid %0b kind %0d code %0d last %0b",
                         r.out_byte, r.byte_valid, r.end_kind, r.error_code, r.last);
    endfunction

    task automatic note_failure(input string what, input decoded_t want, input decoded_t got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s: expected %s, got %s", $realtime, what, describe(want),
                     describe(got));
    endtask

    // Source side: offers the head of the pending queue and predicts each accepted item.
    always @(posedge clk)
    begin
        logic advance;
        if (rst_n)
        begin
            advance = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_source_byte(s_axis_tdata, s_axis_tuser);
                pending_bytes.delete(0);
                advance = 1'b1;
            end
            if (advance)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_bytes[0].in_byte;
                    s_axis_tuser <= pending_bytes[0].interp_open;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure and comparison against the oldest prediction.
    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_byte = m_axis_tdata;
                got.byte_valid = m_axis_tuser[0];
                got.end_kind = m_axis_tuser[2:1];
                got.error_code = m_axis_tuser[5:3];
                got.last = m_axis_tlast;
                if (decoded_bytes.size() == 0)
                    note_failure("unexpected item", '0, got);
                else
                begin
                    want = decoded_bytes.pop_front();
                    if (got !== want)
                        note_failure("mismatch", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 85;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 85;
                end
                default:
                begin
                    sender_idle_pct = 34;
                    receiver_stall_pct = 34;
                end
            endcase
            if (phase == 0)
            begin
                queue_source(8'hFF, 1'b1);
                queue_text("\\t", 1'b0);
                queue_text("\\uD83f", 1'b1);       // surrogate, three bytes
                queue_text("\\u07fF", 1'b0);       // largest two-byte code point
                queue_text("\\u1", 1'b0);
                queue_source(sled_pkg::CHAR_NUL, 1'b0);       // zero byte inside the hex digits
                queue_text("\\uG", 1'b1);          // not a hex digit
                queue_source(sled_pkg::CHAR_BACKSLASH, 1'b0);
                queue_source(sled_pkg::CHAR_NUL, 1'b1);       // zero byte as the escape letter
                queue_text("%(", 1'b1);            // interpolation already open
                queue_text("%x", 1'b0);
                queue_source(sled_pkg::CHAR_NUL, 1'b0);
                queue_source(sled_pkg::CHAR_QUOTE, 1'b1);
            end
            queue_random_fragments(ITEMS_PER_PHASE);
            while (pending_bytes.size() != 0 || s_axis_tvalid || decoded_bytes.size() != 0)
                @(negedge clk);
        end
        repeat (20) @(posedge clk);
        if (decoded_bytes.size() != 0)
            note_failure("missing item", decoded_bytes[0], '0);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
design/sled_pkg.sv
design/sled_core.sv
design/sled_out.sv
design/string_literal_escape_decoder.sv
test/string_literal_escape_decoder_test.sv
